// ===== hdl/crf_pkg.sv =====
// ----------------------------------------------------------------------------
// crf_pkg
// Shared types, constants and helpers for the console dual ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package crf_pkg;

  localparam int RING_DEPTH = 64;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = PTR_W + 1;
  localparam int BYTE_W     = 8;
  localparam int LVL_W      = 6;
  localparam int CMD_W      = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LVL_W-1:0]  lvl_t;

  localparam lvl_t LVL_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LINE_RX    = 3'd0,
    CMD_HOST_READ  = 3'd1,
    CMD_HOST_PEEK  = 3'd2,
    CMD_HOST_WRITE = 3'd3,
    CMD_TX_READY   = 3'd4
  } cmd_t;

  typedef struct packed {
    logic  we;
    ptr_t  waddr;
    byte_t wdata;
    logic  re;
    ptr_t  raddr;
  } ram_req_t;

  typedef struct packed {
    byte_t rx_data;
    logic  rx_data_valid;
    byte_t line_out_byte;
    logic  line_out_valid;
    byte_t forward_byte;
    logic  forward_valid;
    logic  write_accepted;
    logic  echo_dropped;
    logic  rx_dropped;
    lvl_t  rx_level;
    lvl_t  tx_level;
    logic  tx_irq_on;
  } res_t;

  function automatic ptr_t next_slot(ptr_t p);
    ptr_t n;
    begin
      n = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
      return n;
    end
  endfunction

  function automatic lvl_t fill_level(ptr_t w, ptr_t r);
    logic [CNT_W-1:0] d;
    begin
      if (w >= r) begin
        d = {1'b0, w} - {1'b0, r};
      end else begin
        d = CNT_W'(RING_DEPTH) + {1'b0, w} - {1'b0, r};
      end
      if (CNT_W'(d) > CNT_W'(LVL_MAX) && CNT_W > LVL_W) begin
        return LVL_MAX;
      end
      return LVL_W'(d);
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/console_dual_ring_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// console_dual_ring_fifo_unit
// Serial console buffer: receive ring and transmit ring in two RAMs, with
// host read/peek/write, line receive with echo, and transmitter-ready pops.
//
//   channel  ports                        payload
//   in       in_tvalid/in_tready/in_tdata command, byte_in
//   out      out_tvalid/out_tready/...    result fields, both fill levels
//   cfg      cfg_valid/cfg_ready/cfg_data manual_mode
//
// One transfer per cycle while the output is not stalled; each result passes
// through the RAM read stage, then the output register.
// Reset (rst_n low, synchronous) empties both rings and clears manual_mode
// and the irq enable; no clearing pass.
// A stalled output holds the result stage, which then holds the input.
// ----------------------------------------------------------------------------
`default_nettype none

module console_dual_ring_fifo_unit import crf_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [2:0] command, [10:3] byte_in, [15:11] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [7:0] rx_data, [8] rx_data_valid, [16:9] line_out_byte,
  // [17] line_out_valid, [25:18] forward_byte, [26] forward_valid,
  // [27] write_accepted, [28] echo_dropped, [29] rx_dropped,
  // [35:30] rx_level, [41:36] tx_level, [42] tx_irq_on, [47:43] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_data
);

  logic       manual_mode_r;
  logic       out_valid_r;
  res_t       out_r;
  logic       in_fire;
  logic       res_valid, res_ready, busy;
  res_t       res;
  ram_req_t   rx_req, tx_req;
  byte_t      rx_rdata, tx_rdata;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign res_ready = !out_valid_r || out_tready;

  crf_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_req.we),
    .waddr (rx_req.waddr),
    .wdata (rx_req.wdata),
    .re    (rx_req.re),
    .raddr (rx_req.raddr),
    .rdata (rx_rdata)
  );

  crf_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_req.we),
    .waddr (tx_req.waddr),
    .wdata (tx_req.wdata),
    .re    (tx_req.re),
    .raddr (tx_req.raddr),
    .rdata (tx_rdata)
  );

  crf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_cmd      (cmd_t'(in_tdata[CMD_W-1:0])),
    .in_byte     (in_tdata[CMD_W +: BYTE_W]),
    .manual_mode (manual_mode_r),
    .rx_req      (rx_req),
    .tx_req      (tx_req),
    .rx_rdata    (rx_rdata),
    .tx_rdata    (tx_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .busy        (busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      manual_mode_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        manual_mode_r <= cfg_data;
      end
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0,
                       out_r.tx_irq_on,
                       out_r.tx_level,
                       out_r.rx_level,
                       out_r.rx_dropped,
                       out_r.echo_dropped,
                       out_r.write_accepted,
                       out_r.forward_valid,
                       out_r.forward_byte,
                       out_r.line_out_valid,
                       out_r.line_out_byte,
                       out_r.rx_data_valid,
                       out_r.rx_data};

endmodule

`default_nettype wire

// ===== hdl/crf_ram.sv =====
// ----------------------------------------------------------------------------
// crf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/crf_ctrl.sv =====
// ----------------------------------------------------------------------------
// crf_ctrl
// Ring pointers, interrupt enable and the RAM access stage. Pointers move at
// the input transfer; the result forms in the following cycle with the read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crf_ctrl import crf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_fire,
  input  wire cmd_t     in_cmd,
  input  wire byte_t    in_byte,
  input  wire logic     manual_mode,
  output ram_req_t      rx_req,
  output ram_req_t      tx_req,
  input  wire byte_t    rx_rdata,
  input  wire byte_t    tx_rdata,
  output logic          res_valid,
  input  wire logic     res_ready,
  output res_t          res,
  output logic          busy
);

  typedef struct packed {
    byte_t fwd_byte;
    logic  fwd_valid;
    logic  rxd_valid;
    logic  lo_valid;
    logic  write_accepted;
    logic  echo_dropped;
    logic  rx_dropped;
  } s1_t;

  ptr_t  rx_wp_r, rx_wp_nxt, rx_rp_r, rx_rp_nxt;
  ptr_t  tx_wp_r, tx_wp_nxt, tx_rp_r, tx_rp_nxt;
  logic  irq_r, irq_nxt;
  logic  s1_valid_r, s1_valid_nxt;
  s1_t   s1_r, s1_nxt;
  logic  rx_empty, rx_full, tx_empty, tx_full;
  logic  tx_push;

  assign rx_empty = (rx_rp_r == rx_wp_r);
  assign tx_empty = (tx_rp_r == tx_wp_r);
  assign rx_full  = (next_slot(rx_wp_r) == rx_rp_r);
  assign tx_full  = (next_slot(tx_wp_r) == tx_rp_r);

  always_comb begin
    rx_wp_nxt = rx_wp_r;
    rx_rp_nxt = rx_rp_r;
    tx_wp_nxt = tx_wp_r;
    tx_rp_nxt = tx_rp_r;
    irq_nxt   = irq_r;
    s1_nxt    = '0;
    tx_push   = 1'b0;
    rx_req    = '{we: 1'b0, waddr: rx_wp_r, wdata: in_byte, re: 1'b0, raddr: rx_rp_r};
    tx_req    = '{we: 1'b0, waddr: tx_wp_r, wdata: in_byte, re: 1'b0, raddr: tx_rp_r};
    if (in_fire) begin
      case (in_cmd)
        CMD_LINE_RX: begin
          tx_push = 1'b1;
          if (!rx_full) begin
            rx_req.we = 1'b1;
            rx_wp_nxt = next_slot(rx_wp_r);
          end else begin
            s1_nxt.rx_dropped = 1'b1;
          end
          s1_nxt.echo_dropped = tx_full;
          if (manual_mode) begin
            s1_nxt.fwd_byte  = in_byte;
            s1_nxt.fwd_valid = 1'b1;
          end
        end
        CMD_HOST_READ, CMD_HOST_PEEK: begin
          if (!rx_empty) begin
            rx_req.re        = 1'b1;
            s1_nxt.rxd_valid = 1'b1;
            if (in_cmd == CMD_HOST_READ) begin
              rx_rp_nxt = next_slot(rx_rp_r);
            end
          end
        end
        CMD_HOST_WRITE: begin
          tx_push               = 1'b1;
          s1_nxt.write_accepted = !tx_full;
        end
        CMD_TX_READY: begin
          if (tx_empty) begin
            irq_nxt = 1'b0;
          end else begin
            tx_req.re       = 1'b1;
            s1_nxt.lo_valid = 1'b1;
            tx_rp_nxt       = next_slot(tx_rp_r);
          end
        end
        default: begin
        end
      endcase
      if (tx_push) begin
        irq_nxt = 1'b1;
        if (!tx_full) begin
          tx_req.we = 1'b1;
          tx_wp_nxt = next_slot(tx_wp_r);
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (res_valid && res_ready) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wp_r    <= '0;
      rx_rp_r    <= '0;
      tx_wp_r    <= '0;
      tx_rp_r    <= '0;
      irq_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      rx_wp_r    <= rx_wp_nxt;
      rx_rp_r    <= rx_rp_nxt;
      tx_wp_r    <= tx_wp_nxt;
      tx_rp_r    <= tx_rp_nxt;
      irq_r      <= irq_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  assign res_valid = s1_valid_r;
  assign busy      = s1_valid_r && !res_ready;

  always_comb begin
    res                = '0;
    res.rx_data        = s1_r.rxd_valid ? rx_rdata : '0;
    res.rx_data_valid  = s1_r.rxd_valid;
    res.line_out_byte  = s1_r.lo_valid ? tx_rdata : '0;
    res.line_out_valid = s1_r.lo_valid;
    res.forward_byte   = s1_r.fwd_byte;
    res.forward_valid  = s1_r.fwd_valid;
    res.write_accepted = s1_r.write_accepted;
    res.echo_dropped   = s1_r.echo_dropped;
    res.rx_dropped     = s1_r.rx_dropped;
    res.rx_level       = fill_level(rx_wp_r, rx_rp_r);
    res.tx_level       = fill_level(tx_wp_r, tx_rp_r);
    res.tx_irq_on      = irq_r;
  end

  a_tx_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(tx_req.we && tx_req.re))
    else $error("tx ring written and read in one cycle");

  a_irq_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_cmd == CMD_TX_READY && tx_empty) |=> !irq_r)
    else $error("irq enable not cleared on empty tx ring");

  a_rx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && rx_empty) |=> (rx_rp_r == $past(rx_rp_r)))
    else $error("rx read pointer moved on empty ring");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !res_ready) |-> !in_fire)
    else $error("transfer taken while result stage stalled");

endmodule

`default_nettype wire

// ===== tb/console_ring_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// console_ring_checker
// Watches the input, result and configuration channels of the console ring
// buffer, keeps its own copy of both rings, the irq enable and the forward
// mode, and checks every result transfer field by field against the oldest
// predicted result.
// ----------------------------------------------------------------------------
module console_ring_checker
  import crf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic                   cfg_data,
  output int                     fail_count,
  output int                     pending
);

  byte_t       rx_ring [RING_DEPTH];
  byte_t       tx_ring [RING_DEPTH];
  int unsigned rx_head, rx_tail, tx_head, tx_tail;
  logic        tx_irq;
  logic        forward_on;
  res_t        awaited_reports [$];

  function automatic int unsigned wrap_next(int unsigned p);
    return (p + 1) % RING_DEPTH;
  endfunction

  function automatic lvl_t ring_fill(int unsigned wr, int unsigned rd);
    int unsigned n;
    n = (RING_DEPTH + wr - rd) % RING_DEPTH;
    return (n > LVL_MAX) ? LVL_MAX : lvl_t'(n);
  endfunction

  // any push attempt arms the irq, even a rejected one
  function automatic logic tx_append(byte_t b);
    tx_irq = 1'b1;
    if (wrap_next(tx_head) == tx_tail) return 1'b0;
    tx_ring[tx_head] = b;
    tx_head = wrap_next(tx_head);
    return 1'b1;
  endfunction

  function automatic res_t predict_report(logic [CMD_W-1:0] c, byte_t b);
    res_t r;
    r = '0;
    case (c)
      CMD_LINE_RX: begin
        if (wrap_next(rx_head) != rx_tail) begin
          rx_ring[rx_head] = b;
          rx_head = wrap_next(rx_head);
        end else begin
          r.rx_dropped = 1'b1;
        end
        r.echo_dropped = !tx_append(b);
        if (forward_on) begin
          r.forward_byte  = b;
          r.forward_valid = 1'b1;
        end
      end
      CMD_HOST_READ, CMD_HOST_PEEK: begin
        if (rx_tail != rx_head) begin
          r.rx_data       = rx_ring[rx_tail];
          r.rx_data_valid = 1'b1;
          if (c == CMD_HOST_READ) rx_tail = wrap_next(rx_tail);
        end
      end
      CMD_HOST_WRITE: begin
        r.write_accepted = tx_append(b);
      end
      CMD_TX_READY: begin
        if (tx_tail == tx_head) begin
          tx_irq = 1'b0;
        end else begin
          r.line_out_byte  = tx_ring[tx_tail];
          r.line_out_valid = 1'b1;
          tx_tail = wrap_next(tx_tail);
        end
      end
      default: ;
    endcase
    r.rx_level  = ring_fill(rx_head, rx_tail);
    r.tx_level  = ring_fill(tx_head, tx_tail);
    r.tx_irq_on = tx_irq;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (!rst_n) begin
      rx_head    = 0;
      rx_tail    = 0;
      tx_head    = 0;
      tx_tail    = 0;
      tx_irq     = 1'b0;
      forward_on = 1'b0;
      fail_count = 0;
      awaited_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) forward_on = cfg_data;
      if (in_tvalid && in_tready)
        awaited_reports.push_back(predict_report(in_tdata[CMD_W-1:0],
                                                 in_tdata[CMD_W +: BYTE_W]));
      if (out_tvalid && out_tready) begin
        got.rx_data        = out_tdata[7:0];
        got.rx_data_valid  = out_tdata[8];
        got.line_out_byte  = out_tdata[16:9];
        got.line_out_valid = out_tdata[17];
        got.forward_byte   = out_tdata[25:18];
        got.forward_valid  = out_tdata[26];
        got.write_accepted = out_tdata[27];
        got.echo_dropped   = out_tdata[28];
        got.rx_dropped     = out_tdata[29];
        got.rx_level       = out_tdata[35:30];
        got.tx_level       = out_tdata[41:36];
        got.tx_irq_on      = out_tdata[42];
        if (awaited_reports.size() == 0) begin
          $error("result transfer with nothing expected, tdata %h", out_tdata);
          fail_count++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("rx_data", want.rx_data, got.rx_data);
          check_field("rx_data_valid", want.rx_data_valid, got.rx_data_valid);
          check_field("line_out_byte", want.line_out_byte, got.line_out_byte);
          check_field("line_out_valid", want.line_out_valid, got.line_out_valid);
          check_field("forward_byte", want.forward_byte, got.forward_byte);
          check_field("forward_valid", want.forward_valid, got.forward_valid);
          check_field("write_accepted", want.write_accepted, got.write_accepted);
          check_field("echo_dropped", want.echo_dropped, got.echo_dropped);
          check_field("rx_dropped", want.rx_dropped, got.rx_dropped);
          check_field("rx_level", want.rx_level, got.rx_level);
          check_field("tx_level", want.tx_level, got.tx_level);
          check_field("tx_irq_on", want.tx_irq_on, got.tx_irq_on);
        end
      end
    end
    pending = awaited_reports.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the console ring buffer: a directed pass over empty rings,
// both byte extremes, every command and the forward mode, then random phases
// that fill, empty or mix the rings, with random gaps and stalls on
// both channels and a forward mode rewrite between phases.
// ----------------------------------------------------------------------------
module tb;
  import crf_pkg::*;

  localparam int CMD_LAST      = (1 << CMD_W) - 1;
  localparam int RANDOM_ITEMS  = 850;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum {MIX_FILL, MIX_EMPTY, MIX_ANY} traffic_mix_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_data   = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_ready;
  int                     fail_count;
  int                     pending;
  int                     cycles     = 0;
  bit                     in_calm    = 1'b0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  console_dual_ring_fifo_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  console_ring_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  task automatic send_item(input logic [CMD_W-1:0] c, input byte_t b);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - CMD_W - BYTE_W){1'b0}}, b, c};
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CMD_W-1:0] pick_command(traffic_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 75) return CMD_LINE_RX;
        if (roll < 90) return CMD_HOST_WRITE;
        if (roll < 95) return CMD_HOST_PEEK;
        return CMD_TX_READY;
      end
      MIX_EMPTY: begin
        if (roll < 40) return CMD_HOST_READ;
        if (roll < 50) return CMD_HOST_PEEK;
        if (roll < 95) return CMD_TX_READY;
        return CMD_LINE_RX;
      end
      default: begin
        if (roll < 4) return CMD_W'($urandom_range(CMD_TX_READY + 1, CMD_LAST));
        return CMD_W'($urandom_range(CMD_LINE_RX, CMD_TX_READY));
      end
    endcase
  endfunction

  // result side: random stall per transfer, calm stretches now and then
  initial begin : result_sink
    int stall;
    int served;
    bit calm;
    served = 0;
    calm   = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (served % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      served++;
    end
  end

  initial begin : stimulus
    int                counted;
    int                span;
    traffic_mix_t      mix;
    logic [CMD_W-1:0]  c;
    byte_t             b;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty rings, unused commands, extremes, forwarding on
    write_mode(1'b1);
    send_item(CMD_HOST_READ, 8'h00);
    send_item(CMD_HOST_PEEK, 8'hFF);
    send_item(CMD_TX_READY, 8'h00);
    for (int u = CMD_TX_READY + 1; u <= CMD_LAST; u++) send_item(CMD_W'(u), 8'hFF);
    send_item(CMD_LINE_RX, 8'hFF);
    send_item(CMD_LINE_RX, 8'h00);
    send_item(CMD_HOST_PEEK, 8'h00);
    repeat (3) send_item(CMD_HOST_READ, 8'h00);
    send_item(CMD_HOST_WRITE, 8'hFF);
    send_item(CMD_HOST_WRITE, 8'h00);
    repeat (5) send_item(CMD_TX_READY, 8'h00);
    wait_idle();
    write_mode(1'b0);
    send_item(CMD_LINE_RX, 8'hA5);
    send_item(CMD_HOST_WRITE, 8'h5A);
    send_item(CMD_TX_READY, 8'hFF);
    send_item(CMD_HOST_READ, 8'h00);
    wait_idle();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      mix     = traffic_mix_t'($urandom_range(0, 2));
      span    = $urandom_range(40, 150);
      if (span > RANDOM_ITEMS - counted) span = RANDOM_ITEMS - counted;
      in_calm = ($urandom_range(0, 3) == 0);
      write_mode(1'($urandom_range(0, 1)));
      repeat (span) begin
        c = pick_command(mix);
        if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else b = byte_t'($urandom_range(0, 255));
        send_item(c, b);
        if (c <= CMD_TX_READY) counted++;
      end
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
